// ===== sv/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

	// Field limit per line and derived counter width
	localparam int MAX_FIELDS = 64;
	localparam int FCNT_W     = $clog2(MAX_FIELDS + 1);

	// Results one input byte can cause, and queue depth between front and back
	localparam int MAX_RES    = 3;
	localparam int RIDX_W     = $clog2(MAX_RES);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	// Configuration
	localparam int            CAP_W       = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd96;
	localparam logic [0:0]    REG_CAP_IDX = 1'b0;

	// Result kinds
	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_FIELD    = 2'd1;
	localparam logic [1:0] KIND_LINE_END = 2'd2;

	// Special bytes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// One result
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] field_byte;
		logic [7:0] byte_position;
		logic [5:0] field_number;
		logic [7:0] field_length;
		logic       line_done;
	} csvt_res_t;

	// All results of one input byte
	typedef struct packed {
		csvt_res_t [MAX_RES-1:0] res;
		logic [RIDX_W:0]         count;
	} csvt_bundle_t;

endpackage

`default_nettype wire

// ===== sv/csv_field_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// Splits the bytes of a CSV line into fields with quoted-field handling.
//
//   Channel  Dir  Payload                                         Done when
//   s_*      in   tdata: line_byte; tlast: line_last              tvalid&tready
//   m_*      out  tdata: byte,pos,number,length; tuser: kind,done tvalid&tready
//   apb      in   reg 0 field_capacity at address 0               psel&penable&pwrite
//
// One input byte is taken per cycle while s_tready is high; its results (zero
// to three) leave one per cycle from the output register while m_tready is
// high. The parser runs ahead of the output through a four-entry bundle
// queue, so s_tready drops only when that queue is full. Reset puts the
// parser at a field start with capacity 96.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_core import csvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
	input  wire logic        s_tlast,
	// Output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] field_byte, [15:8] byte_position,
	                                    // [21:16] field_number, [29:22] field_length
	output logic [2:0]       m_tuser,   // [1:0] kind, [2] line_done
	output logic             m_tlast,
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [CAP_W-1:0] cap_q;
	logic             q_full;
	logic             q_push;
	csvt_bundle_t     q_bundle;
	logic             q_pop;
	logic             head_valid;
	csvt_bundle_t     head;
	csvt_res_t        out_res;

	// Register write and readback
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAP_IDX) ? {{(32-CAP_W){1'b0}}, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAP_IDX) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	csvt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.cap      (cap_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_bundle (q_bundle)
	);

	csvt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_bundle),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	csvt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_res      (out_res),
		.out_run_last (m_tlast)
	);

	// Pack output payload
	assign m_tdata = {2'b00, out_res.field_length, out_res.field_number,
		out_res.byte_position, out_res.field_byte};
	assign m_tuser = {out_res.line_done, out_res.kind};

endmodule

`default_nettype wire

// ===== sv/csvt_front.sv =====
// ----------------------------------------------------------------------------
// csvt_front
// Accepts line bytes, runs the parse state machine and produces the bundle
// of results each byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_front import csvt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_last,
	input  wire logic [CAP_W-1:0] cap,
	input  wire logic             q_full,
	output logic                  q_push,
	output csvt_bundle_t          q_bundle
);

	localparam logic [2:0] M_START  = 3'd0;
	localparam logic [2:0] M_PLAIN  = 3'd1;
	localparam logic [2:0] M_QUOTED = 3'd2;
	localparam logic [2:0] M_QSEEN  = 3'd3;
	localparam logic [2:0] M_IGNORE = 3'd4;
	localparam logic [2:0] M_DROP   = 3'd5;

	typedef struct packed {
		logic [2:0]        mode;
		logic [7:0]        sc;
		logic [7:0]        kl;
		logic [FCNT_W-1:0] fc;
	} csvt_state_t;

	csvt_state_t  st_q;
	csvt_state_t  st_nx;
	csvt_bundle_t bd;
	logic [CAP_W-1:0] eff_cap;
	logic         accept;

	function automatic void emit(inout csvt_bundle_t b, input csvt_state_t s,
			input logic [1:0] kind, input logic [7:0] data, input logic [7:0] pos,
			input logic [7:0] len, input logic done);
		b.res[b.count[RIDX_W-1:0]] = '{kind: kind, field_byte: data, byte_position: pos,
			field_number: s.fc[5:0], field_length: len, line_done: done};
		b.count = b.count + 1'b1;
	endfunction

	function automatic void store(inout csvt_state_t s, inout csvt_bundle_t b,
			input logic [7:0] data, input logic [CAP_W-1:0] ec);
		if (({1'b0, s.sc} + 9'd1) < ec) begin
			emit(b, s, KIND_BYTE, data, s.sc, 8'd0, 1'b0);
			s.sc = s.sc + 8'd1;
			if (data != CH_SPACE && data != CH_TAB)
				s.kl = s.sc;
		end
	endfunction

	function automatic void end_field(inout csvt_state_t s, inout csvt_bundle_t b,
			input logic line_end);
		emit(b, s, KIND_FIELD, 8'd0, 8'd0, s.kl, line_end);
		s.fc = s.fc + 1'b1;
		s.sc = '0;
		s.kl = '0;
		if (line_end)
			s.mode = M_IGNORE;
		else if (s.fc >= FCNT_W'(MAX_FIELDS))
			s.mode = M_DROP;
		else
			s.mode = M_START;
	endfunction

	function automatic logic is_term(input logic [7:0] data);
		return data == CH_NUL || data == CH_CR || data == CH_LF;
	endfunction

	// Clamp capacity into 1..256
	always_comb begin
		if (cap == '0)
			eff_cap = 9'd1;
		else if (cap > 9'd256)
			eff_cap = 9'd256;
		else
			eff_cap = cap;
	end

	// Mode transition and result generation for one byte
	always_comb begin
		st_nx = st_q;
		bd    = '0;
		unique case (st_q.mode)
			M_START: begin
				if (is_term(in_byte)) begin
					emit(bd, st_nx, KIND_LINE_END, 8'd0, 8'd0, 8'd0, 1'b1);
					st_nx.mode = M_IGNORE;
				end else if (in_byte == CH_COMMA) begin
					end_field(st_nx, bd, 1'b0);
				end else if (in_byte == CH_QUOTE) begin
					st_nx.mode = M_QUOTED;
				end else begin
					st_nx.mode = M_PLAIN;
					store(st_nx, bd, in_byte, eff_cap);
				end
			end
			M_PLAIN: begin
				if (in_byte == CH_COMMA)
					end_field(st_nx, bd, 1'b0);
				else if (is_term(in_byte))
					end_field(st_nx, bd, 1'b1);
				else
					store(st_nx, bd, in_byte, eff_cap);
			end
			M_QUOTED: begin
				if (in_byte == CH_QUOTE)
					st_nx.mode = M_QSEEN;
				else if (in_byte == CH_NUL)
					end_field(st_nx, bd, 1'b1);
				else
					store(st_nx, bd, in_byte, eff_cap);
			end
			M_QSEEN: begin
				if (in_byte == CH_QUOTE) begin
					st_nx.mode = M_QUOTED;
					store(st_nx, bd, in_byte, eff_cap);
				end else if (in_byte == CH_COMMA) begin
					end_field(st_nx, bd, 1'b0);
				end else if (is_term(in_byte)) begin
					end_field(st_nx, bd, 1'b1);
				end else begin
					end_field(st_nx, bd, 1'b0);
					if (st_nx.mode == M_START) begin
						st_nx.mode = M_PLAIN;
						store(st_nx, bd, in_byte, eff_cap);
					end
				end
			end
			default: begin
			end
		endcase

		// Close the line on its final byte and rearm for the next one
		if (in_last) begin
			if (st_nx.mode == M_START || st_nx.mode == M_DROP)
				emit(bd, st_nx, KIND_LINE_END, 8'd0, 8'd0, 8'd0, 1'b1);
			else if (st_nx.mode == M_PLAIN || st_nx.mode == M_QUOTED ||
					st_nx.mode == M_QSEEN)
				end_field(st_nx, bd, 1'b1);
			st_nx = '{mode: M_START, sc: '0, kl: '0, fc: '0};
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (bd.count != '0);
	assign q_bundle = bd;

	// Advance parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: M_START, sc: '0, kl: '0, fc: '0};
		end else if (accept) begin
			st_q <= st_nx;
		end
	end

endmodule

`default_nettype wire

// ===== sv/csvt_queue.sv =====
// ----------------------------------------------------------------------------
// csvt_queue
// Short queue of result bundles between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_queue import csvt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire csvt_bundle_t push_data,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output csvt_bundle_t      head
);

	csvt_bundle_t      mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	// Write storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== sv/csvt_back.sv =====
// ----------------------------------------------------------------------------
// csvt_back
// Walks the results of each queued bundle and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_back import csvt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire csvt_bundle_t head,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output csvt_res_t         out_res,
	output logic              out_run_last
);

	logic [RIDX_W-1:0] idx_q;
	logic              valid_q;
	csvt_res_t         res_q;
	logic              run_last_q;
	logic              load;
	logic              bundle_end;

	assign load       = head_valid && (!valid_q || out_ready);
	assign bundle_end = ({1'b0, idx_q} == (head.count - 1'b1));
	assign pop        = load && bundle_end;

	// Step through the bundle one result per cycle while the output register is free or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (load)
				idx_q <= bundle_end ? '0 : idx_q + 1'b1;
		end
	end

	// Hold result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q      <= head.res[idx_q];
			run_last_q <= bundle_end;
		end
	end

	assign out_valid    = valid_q;
	assign out_res      = res_q;
	assign out_run_last = run_last_q;

endmodule

`default_nettype wire
